// File: rtl/i2c_master_register_transfer_macros.svh
// Assertion macros shared by the RTL of the I2C register transfer master.
// No dependencies; included by the modules that carry assertions.
`ifndef I2C_MASTER_REGISTER_TRANSFER_MACROS_SVH
`define I2C_MASTER_REGISTER_TRANSFER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define I2CMRT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define I2CMRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/i2cmrt_pkg.sv
// Types and constants for the I2C register transfer master.
// No dependencies; imported by i2c_master_register_transfer.
package i2cmrt_pkg;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START,
        PH_TXBIT,
        PH_TXPRE,
        PH_TXACK,
        PH_RXBIT,
        PH_RXACK,
        PH_STOP
    } phase_t;

    typedef enum logic [1:0] {
        ST_ADDRW,
        ST_REG,
        ST_ADDRR,
        ST_DATA
    } stage_t;

    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_LOAD  = 2'd1;
    localparam logic [1:0] ACT_WRITE = 2'd2;
    localparam logic [1:0] ACT_READ  = 2'd3;

    localparam int          BYTE_INDEX_W   = 3;
    localparam int          LEN_W          = 4;
    localparam logic [6:0]  DEV_ADDR_RESET = 7'h27;

endpackage

// File: rtl/i2c_master_register_transfer.sv
// I2C register transfer master: bus sequencer, write buffer and result register.
// Depends on i2cmrt_pkg and i2c_master_register_transfer_macros.svh.
//
// Each input beat is one bus time quantum (tick) and yields exactly one output beat
// with the SCL/SDA levels and status for that tick. An accepted beat is processed in
// the cycle it is taken and its result sits in the output register from the next
// cycle, so one beat per clock is sustained; the slave side stalls only while that
// register is full and the downstream side does not take it. Start actions begin a
// write (address, register, buffered data, stop) or a read (address, register,
// repeated start, address with read bit, received bytes, stop); a NACK from the
// target aborts to stop and flags nack_error on the final stop tick. Load actions
// fill the write buffer and may be issued at any time. The user must write the device
// address register via cfg_wr_en/cfg_wr_data only while no transfer runs; unchecked.
`include "i2c_master_register_transfer_macros.svh"

module i2c_master_register_transfer
    import i2cmrt_pkg::*;
#(
    parameter int MAX_LEN = 8
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data,   // device_address

    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] register_address, [11:8] transfer_length, [19:12] write_byte,
    // [22:20] byte_index, [23] sda_sample
    input  logic [23:0] s_tdata,
    input  logic [1:0]  s_tuser,       // action

    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] scl_level, [1] sda_level, [2] sda_drive, [3] busy_res,
    // [11:4] read_data, [12] done_res, [13] nack_error, [15:14] zero
    output logic [15:0] m_tdata,
    output logic        m_tuser,       // read_valid
    output logic        m_tlast        // read_last
);

    localparam int BUF_SLOTS = 1 << BYTE_INDEX_W;
    localparam int BUF_DEPTH = (MAX_LEN < BUF_SLOTS) ? MAX_LEN : BUF_SLOTS;
    localparam int IDX_W     = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int LEN_MAX   = (1 << LEN_W) - 1;
    localparam int LEN_CAP   = (MAX_LEN < LEN_MAX) ? MAX_LEN : LEN_MAX;

    // Input beat fields.
    logic [1:0]              action;
    logic [7:0]              reg_addr_in;
    logic [LEN_W-1:0]        len_in;
    logic [7:0]              wbyte_in;
    logic [BYTE_INDEX_W-1:0] widx_in;
    logic                    sda_in;

    assign action      = s_tuser;
    assign reg_addr_in = s_tdata[7:0];
    assign len_in      = s_tdata[11:8];
    assign wbyte_in    = s_tdata[19:12];
    assign widx_in     = s_tdata[22:20];
    assign sda_in      = s_tdata[23];

    // Sequencer state.
    phase_t           phase_reg, phase_next;
    stage_t           stage_reg, stage_next;
    logic [3:0]       bit_reg, bit_next;
    logic [LEN_W-1:0] bc_reg, bc_next;
    logic [7:0]       shift_reg, shift_next;
    logic             is_read_reg, is_read_next;
    logic [LEN_W-1:0] rem_reg, rem_next;
    logic [7:0]       treg_reg, treg_next;
    logic             abort_reg, abort_next;
    logic [6:0]       dev_reg;
    logic [7:0]       wbuf_reg [BUF_DEPTH];

    // Output register.
    logic             out_valid_reg;
    logic [15:0]      out_data_reg;
    logic             out_user_reg;
    logic             out_last_reg;

    logic in_fire;
    logic start_now;
    logic load_hit;

    phase_t     cur_phase;
    stage_t     cur_stage;
    logic [3:0] cur_bit;

    logic [LEN_W-1:0] data_idx;
    logic [7:0]       data_byte;
    logic [7:0]       addr_w_byte;
    logic [7:0]       addr_r_byte;
    logic [LEN_W:0]   bc_inc;
    logic             rx_last;
    logic [LEN_W-1:0] len_sat;

    logic       scl_c, sda_c, drv_c, busy_c, rv_c, rl_c, done_c, nerr_c;
    logic [7:0] rd_c;

    assign s_tready  = !out_valid_reg || m_tready;
    assign in_fire   = s_tvalid && s_tready;
    assign start_now = (phase_reg == PH_IDLE) && (action == ACT_WRITE || action == ACT_READ);
    assign load_hit  = (action == ACT_LOAD) && ({1'b0, widx_in} < LEN_W'(BUF_DEPTH));

    assign cur_phase = start_now ? PH_START : phase_reg;
    assign cur_stage = start_now ? ST_ADDRW : stage_reg;
    assign cur_bit   = start_now ? 4'd0 : bit_reg;

    assign addr_w_byte = {dev_reg, 1'b0};
    assign addr_r_byte = {dev_reg, 1'b1};
    assign bc_inc      = {1'b0, bc_reg} + 1'b1;
    assign rx_last     = bc_inc >= {1'b0, rem_reg};
    assign len_sat     = (len_in > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : len_in;

    // The first data byte follows the register byte; later ones follow the previous
    // data byte. A load to the same slot in this beat is seen by the read.
    assign data_idx = (stage_reg == ST_DATA) ? bc_inc[LEN_W-1:0] : '0;

    always_comb
    begin
        data_byte = 8'h00;
        if (data_idx < LEN_W'(BUF_DEPTH))
        begin
            if (load_hit && ({1'b0, widx_in} == data_idx))
                data_byte = wbyte_in;
            else
                data_byte = wbuf_reg[data_idx[IDX_W-1:0]];
        end
    end

    // Next-state logic.
    always_comb
    begin
        phase_next   = phase_reg;
        stage_next   = stage_reg;
        bit_next     = bit_reg;
        bc_next      = bc_reg;
        shift_next   = shift_reg;
        is_read_next = is_read_reg;
        rem_next     = rem_reg;
        treg_next    = treg_reg;
        abort_next   = abort_reg;

        if (start_now)
        begin
            is_read_next = (action == ACT_READ);
            treg_next    = reg_addr_in;
            rem_next     = len_sat;
            bc_next      = '0;
            shift_next   = 8'h00;
            stage_next   = ST_ADDRW;
            abort_next   = 1'b0;
        end

        case (cur_phase)
            PH_START:
            begin
                if (cur_bit >= 4'd3)
                begin
                    shift_next = (cur_stage == ST_ADDRR) ? addr_r_byte : addr_w_byte;
                    phase_next = PH_TXBIT;
                    bit_next   = 4'd0;
                end
                else
                begin
                    phase_next = PH_START;
                    bit_next   = cur_bit + 4'd1;
                end
            end
            PH_TXBIT:
            begin
                if (cur_bit == 4'd15)
                begin
                    phase_next = PH_TXPRE;
                    bit_next   = 4'd0;
                end
                else
                    bit_next = cur_bit + 4'd1;
            end
            PH_TXPRE:
            begin
                phase_next = PH_TXACK;
                bit_next   = 4'd0;
            end
            PH_TXACK:
            begin
                bit_next = 4'd0;
                if (sda_in)
                begin
                    abort_next = 1'b1;
                    phase_next = PH_STOP;
                end
                else
                begin
                    case (stage_reg)
                        ST_ADDRW:
                        begin
                            stage_next = ST_REG;
                            shift_next = treg_reg;
                            phase_next = PH_TXBIT;
                        end
                        ST_REG:
                        begin
                            if (is_read_reg)
                            begin
                                stage_next = ST_ADDRR;
                                phase_next = PH_START;
                            end
                            else if (rem_reg == '0)
                                phase_next = PH_STOP;
                            else
                            begin
                                bc_next    = '0;
                                stage_next = ST_DATA;
                                shift_next = data_byte;
                                phase_next = PH_TXBIT;
                            end
                        end
                        ST_ADDRR:
                        begin
                            if (rem_reg == '0)
                                phase_next = PH_STOP;
                            else
                            begin
                                bc_next    = '0;
                                shift_next = 8'h00;
                                phase_next = PH_RXBIT;
                            end
                        end
                        default:
                        begin
                            bc_next = bc_inc[LEN_W-1:0];
                            if (bc_inc >= {1'b0, rem_reg})
                                phase_next = PH_STOP;
                            else
                            begin
                                shift_next = data_byte;
                                phase_next = PH_TXBIT;
                            end
                        end
                    endcase
                end
            end
            PH_RXBIT:
            begin
                // SDA is sampled on the high half of each received bit.
                if (!cur_bit[0])
                    shift_next = {shift_reg[6:0], sda_in};
                if (cur_bit == 4'd15)
                begin
                    phase_next = PH_RXACK;
                    bit_next   = 4'd0;
                end
                else
                    bit_next = cur_bit + 4'd1;
            end
            PH_RXACK:
            begin
                if (cur_bit >= 4'd2)
                begin
                    bc_next  = bc_inc[LEN_W-1:0];
                    bit_next = 4'd0;
                    if (rx_last)
                        phase_next = PH_STOP;
                    else
                    begin
                        shift_next = 8'h00;
                        phase_next = PH_RXBIT;
                    end
                end
                else
                    bit_next = cur_bit + 4'd1;
            end
            PH_STOP:
            begin
                if (cur_bit >= 4'd3)
                begin
                    abort_next = 1'b0;
                    phase_next = PH_IDLE;
                    bit_next   = 4'd0;
                end
                else
                    bit_next = cur_bit + 4'd1;
            end
            default:
            begin
                phase_next = PH_IDLE;
                bit_next   = 4'd0;
            end
        endcase
    end

    // Pin levels and status for this tick.
    always_comb
    begin
        scl_c  = 1'b1;
        sda_c  = 1'b0;
        drv_c  = 1'b0;
        busy_c = 1'b1;
        rv_c   = 1'b0;
        rd_c   = 8'h00;
        rl_c   = 1'b0;
        done_c = 1'b0;
        nerr_c = 1'b0;

        case (cur_phase)
            PH_START:
            begin
                drv_c = 1'b1;
                case (cur_bit)
                    4'd0:
                    begin
                        // A repeated start begins with SCL low.
                        scl_c = (cur_stage != ST_ADDRR);
                        sda_c = 1'b1;
                    end
                    4'd1:
                    begin
                        scl_c = 1'b1;
                        sda_c = 1'b1;
                    end
                    4'd2:
                    begin
                        scl_c = 1'b1;
                        sda_c = 1'b0;
                    end
                    default:
                    begin
                        scl_c = 1'b0;
                        sda_c = 1'b0;
                    end
                endcase
            end
            PH_TXBIT:
            begin
                drv_c = 1'b1;
                scl_c = !cur_bit[0];
                sda_c = shift_reg[3'd7 - cur_bit[3:1]];
            end
            PH_TXPRE:
            begin
                drv_c = 1'b1;
                scl_c = 1'b0;
                sda_c = 1'b1;
            end
            PH_TXACK:
                scl_c = 1'b1;
            PH_RXBIT:
                scl_c = !cur_bit[0];
            PH_RXACK:
            begin
                drv_c = 1'b1;
                sda_c = rx_last;
                scl_c = (cur_bit == 4'd1);
                if (cur_bit >= 4'd2)
                begin
                    rv_c = 1'b1;
                    rd_c = shift_reg;
                    rl_c = rx_last;
                end
            end
            PH_STOP:
            begin
                drv_c = 1'b1;
                scl_c = (cur_bit >= 4'd2);
                sda_c = (cur_bit == 4'd0) || (cur_bit >= 4'd3);
                if (cur_bit >= 4'd3)
                begin
                    done_c = 1'b1;
                    nerr_c = abort_reg;
                end
            end
            default:
                busy_c = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            stage_reg   <= ST_ADDRW;
            bit_reg     <= 4'd0;
            bc_reg      <= '0;
            shift_reg   <= 8'h00;
            is_read_reg <= 1'b0;
            rem_reg     <= '0;
            treg_reg    <= 8'h00;
            abort_reg   <= 1'b0;
        end
        else if (in_fire)
        begin
            phase_reg   <= phase_next;
            stage_reg   <= stage_next;
            bit_reg     <= bit_next;
            bc_reg      <= bc_next;
            shift_reg   <= shift_next;
            is_read_reg <= is_read_next;
            rem_reg     <= rem_next;
            treg_reg    <= treg_next;
            abort_reg   <= abort_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dev_reg <= DEV_ADDR_RESET;
        else if (cfg_wr_en)
            dev_reg <= cfg_wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && load_hit)
            wbuf_reg[widx_in[IDX_W-1:0]] <= wbyte_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_data_reg <= {2'b00, nerr_c, done_c, rd_c, busy_c, drv_c, sda_c, scl_c};
            out_user_reg <= rv_c;
            out_last_reg <= rl_c;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    `I2CMRT_ASSERT_NOW(a_idle_clean, clk, rst_n, phase_reg == PH_IDLE, (bit_reg == 4'd0) && !abort_reg, "idle phase with live counter or abort flag")
    `I2CMRT_ASSERT_NEXT(a_done_to_idle, clk, rst_n, in_fire && done_c, phase_reg == PH_IDLE, "stop tick did not return to idle")
    `I2CMRT_ASSERT_NOW(a_nack_with_done, clk, rst_n, m_tvalid && m_tdata[13], m_tdata[12] && m_tdata[3], "nack error flagged outside the final stop tick")
    `I2CMRT_ASSERT_NOW(a_rx_count, clk, rst_n, phase_reg == PH_RXBIT || phase_reg == PH_RXACK, bc_reg < rem_reg, "receive byte count beyond transfer length")
    `I2CMRT_ASSERT_NOW(a_stall, clk, rst_n, m_tvalid && !m_tready, !s_tready, "beat accepted while result register is stalled")

endmodule
